@@ rtl/bvr_pkg.sv @@
package bvr_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_FRAC_BITS  = 8;

    localparam logic [10:0] RST_SOURCE_HEIGHT = 11'd1024;
    localparam logic [10:0] RST_LUMA_STRIDE   = 11'd1024;
    localparam logic [9:0]  RST_CHROMA_STRIDE = 10'd512;
    localparam logic [10:0] RST_DEST_WIDTH    = 11'd1024;

    typedef enum logic [1:0] {
        OP_LOAD_LUMA = 2'd0,
        OP_LOAD_U    = 2'd1,
        OP_LOAD_V    = 2'd2,
        OP_REMAP     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        REG_SOURCE_HEIGHT = 2'd0,
        REG_LUMA_STRIDE   = 2'd1,
        REG_CHROMA_STRIDE = 2'd2,
        REG_DEST_WIDTH    = 2'd3
    } t_reg;

    typedef struct packed {
        logic [7:0] p0;
        logic [7:0] p1;
        logic [7:0] p2;
        logic [7:0] p3;
    } t_pix4;

endpackage

@@ rtl/bvr_pair_store.sv @@
module bvr_pair_store import bvr_pkg::*; #(
    parameter int AW = 20
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_base_a,
    input  logic [AW-1:0] i_base_b,
    output t_pix4         o_pix
);

    localparam int HW    = AW - 1;
    localparam int DEPTH = 2 ** HW;

    // even and odd address banks, each read at two rows
    logic [7:0] r_even [DEPTH];
    logic [7:0] r_odd  [DEPTH];

    logic [HW-1:0] idx_even_a, idx_odd_a, idx_even_b, idx_odd_b;
    logic [7:0] r_qe_a, r_qo_a, r_qe_b, r_qo_b;
    logic r_sw_a, r_sw_b;

    assign idx_odd_a  = i_base_a[AW-1:1];
    assign idx_even_a = i_base_a[AW-1:1] + HW'(i_base_a[0]);
    assign idx_odd_b  = i_base_b[AW-1:1];
    assign idx_even_b = i_base_b[AW-1:1] + HW'(i_base_b[0]);

    always_ff @(posedge i_clk) begin
        if (i_we && !i_waddr[0]) begin
            r_even[i_waddr[AW-1:1]] <= i_wdata;
        end
        if (i_we && i_waddr[0]) begin
            r_odd[i_waddr[AW-1:1]] <= i_wdata;
        end
        if (i_re) begin
            r_qe_a <= r_even[idx_even_a];
            r_qo_a <= r_odd[idx_odd_a];
            r_qe_b <= r_even[idx_even_b];
            r_qo_b <= r_odd[idx_odd_b];
            r_sw_a <= i_base_a[0];
            r_sw_b <= i_base_b[0];
        end
    end

    always_comb begin
        o_pix.p0 = r_sw_a ? r_qo_a : r_qe_a;
        o_pix.p1 = r_sw_a ? r_qe_a : r_qo_a;
        o_pix.p2 = r_sw_b ? r_qo_b : r_qe_b;
        o_pix.p3 = r_sw_b ? r_qe_b : r_qo_b;
    end

endmodule

@@ rtl/bilinear_yuv420_remap_core.sv @@
// Bilinear YUV420 remap core. One item (a load byte or a remap pixel) is taken per clock
// while the output side keeps up; remap results leave through a skid-buffered output.
// The rate is set by the source stores: each plane is split into even and odd address
// banks, each bank read at two addresses per cycle, so all four neighbours of a plane
// come out of one read. Loads write the stores at the same pipeline stage where remaps
// read them, so item order is kept with no interlock. The stores are not cleared after
// reset; only written entries give defined pixels. Configuration is taken on any cycle
// and must only change while the core is idle. MAX_WIDTH and MAX_HEIGHT must be powers
// of two.
module bilinear_yuv420_remap_core import bvr_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // load_addr, load_value, map_x, map_y, out_row, out_col
    input  logic [87:0] i_s_tdata,
    // operation
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // luma_value, luma_addr, chroma_u, chroma_v, chroma_addr, zero fill
    output logic [63:0] o_m_tdata,
    // luma_written, chroma_written
    output logic [1:0]  o_m_tuser
);

    localparam int LAW = $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT);
    localparam int CAW = LAW - 2;
    localparam int CW  = 20 - FRAC_BITS;
    localparam int TW  = 9 + FRAC_BITS;
    localparam int VW  = TW + FRAC_BITS + 1;
    localparam logic [FRAC_BITS:0] S = (FRAC_BITS + 1)'(1) << FRAC_BITS;

    typedef struct packed {
        t_op                  op;
        logic                 ok;
        logic                 chroma;
        logic [FRAC_BITS-1:0] fx;
        logic [FRAC_BITS-1:0] fy;
        logic [19:0]          laddr;
        logic [17:0]          caddr;
        logic [19:0]          ld_addr;
        logic [7:0]           ld_val;
    } t_meta;

    function automatic logic [TW-1:0] blend_row(input logic [7:0] a, input logic [7:0] b,
                                                input logic [FRAC_BITS:0] w0,
                                                input logic [FRAC_BITS:0] w1);
        blend_row = TW'(a) * TW'(w0) + TW'(b) * TW'(w1);
    endfunction

    function automatic logic [7:0] blend_col(input logic [TW-1:0] t, input logic [TW-1:0] b,
                                             input logic [FRAC_BITS:0] w0,
                                             input logic [FRAC_BITS:0] w1);
        logic [VW-1:0] sum;
        sum = VW'(t) * VW'(w0) + VW'(b) * VW'(w1);
        blend_col = sum[2*FRAC_BITS+7:2*FRAC_BITS];
    endfunction

    logic [10:0] r_height, r_lstride, r_dwidth;
    logic [9:0]  r_cstride;

    logic adv;
    logic r_out_v, r_skid_v;
    logic [63:0] r_out_data, r_skid_data;
    logic [1:0]  r_out_user, r_skid_user;

    assign adv         = !r_skid_v;
    assign o_s_tready  = adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height  <= RST_SOURCE_HEIGHT;
            r_lstride <= RST_LUMA_STRIDE;
            r_cstride <= RST_CHROMA_STRIDE;
            r_dwidth  <= RST_DEST_WIDTH;
        end else if (i_cfg_valid) begin
            case (t_reg'(i_cfg_index))
                REG_SOURCE_HEIGHT: r_height  <= i_cfg_data;
                REG_LUMA_STRIDE:   r_lstride <= i_cfg_data;
                REG_CHROMA_STRIDE: r_cstride <= i_cfg_data[9:0];
                REG_DEST_WIDTH:    r_dwidth  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline registers
    logic r1_v, r2_v, r3_v, r4_v, r5_v, r6_v;
    t_meta r1_m, r2_m, r3_m, r4_m, r5_m, r6_m;
    logic [19:0] r1_mx, r1_my;
    logic [9:0]  r1_orow, r1_ocol, r2_orow, r2_ocol, r3_ocol;
    logic [LAW-1:0] r2_rowc, r3_lrow, r4_la, r4_lb;
    logic [CAW-1:0] r2_half, r3_crow, r4_ca, r4_cb;
    logic [CW-1:0]  r2_col, r3_col;
    logic [19:0] r3_lo;
    logic [17:0] r3_co;
    logic [TW-1:0] r6_lt, r6_lb, r6_ut, r6_ub, r6_vt, r6_vb;

    // decode and bottom clamp
    logic signed [23:0] row_s, lim, rowc, half;
    t_meta m1;

    always_comb begin
        row_s = 24'(r1_my[19:FRAC_BITS]);
        lim   = 24'(r_height) - 24'sd2;
        if (row_s >= lim) begin
            rowc = lim - 24'sd1;
            half = (row_s >>> 1) - (row_s - lim + 24'sd1);
        end else begin
            rowc = row_s;
            half = row_s >>> 1;
        end
        m1        = r1_m;
        m1.ok     = !r1_mx[19] && !r1_my[19] && !rowc[23];
        m1.chroma = !r1_orow[0] && !r1_ocol[0];
        m1.fx     = r1_mx[FRAC_BITS-1:0];
        m1.fy     = r1_my[FRAC_BITS-1:0];
    end

    t_meta m3;

    always_comb begin
        m3       = r3_m;
        m3.laddr = r3_lo + 20'(r3_ocol);
        m3.caddr = r3_co + 18'(r3_ocol[9:1]);
    end

    t_meta m0;

    always_comb begin
        m0         = '0;
        m0.op      = t_op'(i_s_tuser);
        m0.ld_addr = i_s_tdata[19:0];
        m0.ld_val  = i_s_tdata[27:20];
    end

    t_pix4 pl, pu, pv;
    logic [FRAC_BITS:0] wx0, wx1, wy0, wy1, vy0, vy1;

    assign wx1 = (FRAC_BITS + 1)'(r5_m.fx);
    assign wx0 = S - wx1;
    assign vy1 = (FRAC_BITS + 1)'(r6_m.fy);
    assign vy0 = S - vy1;
    assign wy0 = vy0;
    assign wy1 = vy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else if (adv) begin
            r1_v <= i_s_tvalid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
        end
        if (adv) begin
            r1_m         <= m0;
            r1_mx        <= i_s_tdata[47:28];
            r1_my        <= i_s_tdata[67:48];
            r1_orow      <= i_s_tdata[77:68];
            r1_ocol      <= i_s_tdata[87:78];

            r2_m    <= m1;
            r2_rowc <= LAW'(rowc);
            r2_half <= CAW'(half);
            r2_col  <= r1_mx[19:FRAC_BITS];
            r2_orow <= r1_orow;
            r2_ocol <= r1_ocol;

            r3_m    <= r2_m;
            r3_lrow <= LAW'(r2_rowc) * LAW'(r_lstride);
            r3_crow <= CAW'(r2_half) * CAW'(r_cstride);
            r3_col  <= r2_col;
            r3_lo   <= 20'(r2_orow) * 20'(r_dwidth);
            r3_co   <= 18'(r2_orow[9:1]) * 18'(r_dwidth[10:1]);
            r3_ocol <= r2_ocol;

            r4_m  <= m3;
            r4_la <= r3_lrow + LAW'(r3_col);
            r4_lb <= r3_lrow + LAW'(r3_col) + LAW'(r_lstride);
            r4_ca <= r3_crow + CAW'(r3_col[CW-1:1]);
            r4_cb <= r3_crow + CAW'(r3_col[CW-1:1]) + CAW'(r_cstride);

            r5_m <= r4_m;

            r6_m  <= r5_m;
            r6_lt <= blend_row(pl.p0, pl.p1, wx0, wx1);
            r6_lb <= blend_row(pl.p2, pl.p3, wx0, wx1);
            r6_ut <= blend_row(pu.p0, pu.p1, wx0, wx1);
            r6_ub <= blend_row(pu.p2, pu.p3, wx0, wx1);
            r6_vt <= blend_row(pv.p0, pv.p1, wx0, wx1);
            r6_vb <= blend_row(pv.p2, pv.p3, wx0, wx1);
        end
    end

    logic we_l, we_u, we_v;

    assign we_l = adv && r4_v && (r4_m.op == OP_LOAD_LUMA);
    assign we_u = adv && r4_v && (r4_m.op == OP_LOAD_U);
    assign we_v = adv && r4_v && (r4_m.op == OP_LOAD_V);

    bvr_pair_store #(.AW(LAW)) u_luma (
        .i_clk    (i_clk),
        .i_we     (we_l),
        .i_waddr  (LAW'(r4_m.ld_addr)),
        .i_wdata  (r4_m.ld_val),
        .i_re     (adv),
        .i_base_a (r4_la),
        .i_base_b (r4_lb),
        .o_pix    (pl)
    );

    bvr_pair_store #(.AW(CAW)) u_ustore (
        .i_clk    (i_clk),
        .i_we     (we_u),
        .i_waddr  (CAW'(r4_m.ld_addr)),
        .i_wdata  (r4_m.ld_val),
        .i_re     (adv),
        .i_base_a (r4_ca),
        .i_base_b (r4_cb),
        .o_pix    (pu)
    );

    bvr_pair_store #(.AW(CAW)) u_vstore (
        .i_clk    (i_clk),
        .i_we     (we_v),
        .i_waddr  (CAW'(r4_m.ld_addr)),
        .i_wdata  (r4_m.ld_val),
        .i_re     (adv),
        .i_base_a (r4_ca),
        .i_base_b (r4_cb),
        .o_pix    (pv)
    );

    // final blend and result packing
    logic res_v, lw, cw;
    logic [63:0] n_data;

    always_comb begin
        res_v  = r6_v && (r6_m.op == OP_REMAP);
        lw     = r6_m.ok;
        cw     = r6_m.ok && r6_m.chroma;
        n_data = '0;
        if (lw) begin
            n_data[7:0]  = blend_col(r6_lt, r6_lb, wy0, wy1);
            n_data[27:8] = r6_m.laddr;
        end
        if (cw) begin
            n_data[35:28] = blend_col(r6_ut, r6_ub, wy0, wy1);
            n_data[43:36] = blend_col(r6_vt, r6_vb, wy0, wy1);
            n_data[61:44] = r6_m.caddr;
        end
    end

    // output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_out_v && !i_m_tready) begin
            if (adv && res_v) begin
                r_skid_v    <= 1'b1;
                r_skid_data <= n_data;
                r_skid_user <= {cw, lw};
            end
        end else if (r_skid_v) begin
            r_out_v    <= 1'b1;
            r_out_data <= r_skid_data;
            r_out_user <= r_skid_user;
            r_skid_v   <= 1'b0;
        end else begin
            r_out_v    <= res_v;
            r_out_data <= n_data;
            r_out_user <= {cw, lw};
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid holds a transfer while output is empty");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && !i_m_tready))
        else $error("skid filled without an output stall");

    a_chroma_implies_luma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out_user[1]) |-> r_out_user[0])
        else $error("chroma written without luma");

    a_suppressed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !r_out_user[0]) |-> (r_out_data == 64'd0))
        else $error("suppressed result carries data");

endmodule
